// ===== design/nrci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrci_pkg
// Shared types and constants for the name registry check/insert block.
// ----------------------------------------------------------------------------
package nrci_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_RECV,     // collecting name bytes
    S_CHECK,    // length / character check
    S_LEN_CHK,  // stored length of one entry visible
    S_CMP,      // byte-by-byte compare against one entry
    S_FIN       // deliver result, update table
  } state_t;

  // Status codes on the result
  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_IN_USE   = 2'd2;

  // Extra allowed characters
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;

  // Payload widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

endpackage

// ===== design/name_registry_check_insert_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_registry_check_insert_top
// Checks a candidate name and appends it to a table of unique names.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one name byte per transfer, tuser = byte present,
//   tlast marks the final transfer of a name. An empty name is a single
//   transfer with tuser low and tlast high.
//   Output stream (m_axis_*): one status transfer per name.
// Flow:
//   Bytes are taken one per cycle in S_RECV. After the tlast transfer the
//   controller walks the stored entries through the name memory, one read
//   per cycle: a check step, then per stored entry a length check and, when
//   the length matches, a byte-by-byte compare, then a step to post the
//   result. Input is held off during this walk and until the result is posted;
//   the name memory has a single read port.
// Reset:
//   rst clears the entry count and the pending name state; the name and
//   length memories need no clearing because only written entries are compared.
// Stall:
//   The result sits in an output register; the next name's bytes are taken
//   while it waits, and only the next result waits for it to be taken.
// ----------------------------------------------------------------------------
module name_registry_check_insert_top #(
  parameter int MAX_ENTRIES = 16,
  parameter int NAME_LEN    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [nrci_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] name_byte
  input  logic                         s_axis_tuser,   // [0] byte_present
  input  logic                         s_axis_tlast,   // end_of_name
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata    // [1:0] login_status,
                                                       // [2] was_stored,
                                                       // [7:3] entries_in_use
);
  import nrci_pkg::*;

  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int BW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int LW = $clog2(NAME_LEN + 2);
  localparam int DEPTH = MAX_ENTRIES * NAME_LEN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // state
  state_t            state, state_next;
  logic [LW-1:0]     pending_length;
  logic              bad_char_seen;
  logic [CW-1:0]     entry_count;
  logic [EW-1:0]     ent_idx;
  logic [BW-1:0]     cmp_pos;
  logic [STATUS_W-1:0] res_status;
  logic              res_stored;
  logic              out_valid;
  logic [7:0]        out_data;

  // memories
  logic [BYTE_W-1:0] pending_name   [NAME_LEN];
  logic [BYTE_W-1:0] stored_names   [DEPTH];
  logic [LW-1:0]     stored_lengths [MAX_ENTRIES];
  logic [BYTE_W-1:0] pend_q;
  logic [BYTE_W-1:0] name_q;
  logic [LW-1:0]     len_q;

  // control
  logic              s_accept;
  logic              byte_ok;
  logic              pend_we;
  logic              name_we;
  logic [AW-1:0]     name_waddr;
  logic [AW-1:0]     name_raddr;
  logic [EW-1:0]     ent_nx;
  logic [BW-1:0]     pos_nx;
  logic              res_load;
  logic [STATUS_W-1:0] res_status_nx;
  logic              res_stored_nx;
  logic              fin_fire;
  logic              name_bad;
  logic              has_room;
  logic              len_match;
  logic              byte_match;
  logic              last_ent;
  logic              last_byte;
  logic [CW-1:0]     count_nx;

  function automatic logic char_allowed(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                     CHAR_UNDERSCORE, CHAR_HYPHEN};
  endfunction

  // Handshake and compare terms
  assign s_axis_tready = (state == S_RECV);
  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign byte_ok    = char_allowed(s_axis_tdata);
  assign pend_we    = s_accept && s_axis_tuser && (pending_length < LW'(NAME_LEN));
  assign has_room   = entry_count < CW'(MAX_ENTRIES);
  assign name_we    = pend_we && has_room;
  assign name_bad   = (pending_length == '0) || (pending_length > LW'(NAME_LEN)) ||
                      bad_char_seen;
  assign len_match  = (len_q == pending_length);
  assign byte_match = (name_q == pend_q);
  assign last_ent   = (CW'(ent_idx) + CW'(1)) == entry_count;
  assign last_byte  = (LW'(cmp_pos) + LW'(1)) == pending_length;
  assign fin_fire   = (state == S_FIN) && (!out_valid || m_axis_tready);

  // Bytes go straight into the next free slot while the table has room; only entries below the count
  // are ever compared, so an unused slot may hold a rejected name.
  assign name_waddr = AW'(entry_count) * AW'(NAME_LEN) + AW'(pending_length);
  assign name_raddr = AW'(ent_nx) * AW'(NAME_LEN) + AW'(pos_nx);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_RECV: begin
        if (s_accept && s_axis_tlast) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (name_bad || entry_count == '0) state_next = S_FIN;
        else state_next = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (len_match) state_next = S_CMP;
        else if (last_ent) state_next = S_FIN;
      end
      S_CMP: begin
        if (!byte_match) state_next = last_ent ? S_FIN : S_LEN_CHK;
        else if (last_byte) state_next = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) state_next = S_RECV;
      end
      default: state_next = S_RECV;
    endcase
  end

  // Walk addresses and result decision
  always_comb begin
    ent_nx        = ent_idx;
    pos_nx        = cmp_pos;
    res_load      = 1'b0;
    res_status_nx = STAT_ACCEPTED;
    res_stored_nx = 1'b0;
    case (state)
      S_CHECK: begin
        ent_nx = '0;
        pos_nx = '0;
        if (name_bad) begin
          res_load      = 1'b1;
          res_status_nx = STAT_INVALID;
        end else if (entry_count == '0) begin
          res_load      = 1'b1;
          res_stored_nx = has_room;
        end
      end
      S_LEN_CHK: begin
        pos_nx = '0;
        if (!len_match) begin
          if (last_ent) begin
            res_load      = 1'b1;
            res_stored_nx = has_room;
          end else begin
            ent_nx = ent_idx + EW'(1);
          end
        end
      end
      S_CMP: begin
        if (!byte_match) begin
          pos_nx = '0;
          if (last_ent) begin
            res_load      = 1'b1;
            res_stored_nx = has_room;
          end else begin
            ent_nx = ent_idx + EW'(1);
          end
        end else if (last_byte) begin
          res_load      = 1'b1;
          res_status_nx = STAT_IN_USE;
        end else begin
          pos_nx = cmp_pos + BW'(1);
        end
      end
      default: ;
    endcase
  end

  assign count_nx  = entry_count + CW'(res_stored);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RECV;
      pending_length <= '0;
      bad_char_seen  <= 1'b0;
      entry_count    <= '0;
      ent_idx        <= '0;
      cmp_pos        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state   <= state_next;
      ent_idx <= ent_nx;
      cmp_pos <= pos_nx;
      if (s_accept && s_axis_tuser) begin
        if (!byte_ok) bad_char_seen <= 1'b1;
        if (pending_length <= LW'(NAME_LEN)) pending_length <= pending_length + LW'(1);
      end
      if (fin_fire) begin
        pending_length <= '0;
        bad_char_seen  <= 1'b0;
        entry_count    <= count_nx;
        out_valid      <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_nx;
      res_stored <= res_stored_nx;
    end
    if (fin_fire) out_data <= {COUNT_W'(count_nx), res_stored, res_status};
  end

  // Pending name memory; written in S_RECV, its read data used only from
  // S_CHECK on, so a used read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (pend_we) pending_name[pending_length[BW-1:0]] <= s_axis_tdata;
    pend_q <= pending_name[pos_nx];
  end

  // Stored name memory
  always_ff @(posedge clk) begin
    if (name_we) stored_names[name_waddr] <= s_axis_tdata;
    name_q <= stored_names[name_raddr];
  end

  // Stored length memory; written when an entry is committed
  always_ff @(posedge clk) begin
    if (fin_fire && res_stored) stored_lengths[entry_count[EW-1:0]] <= pending_length;
    len_q <= stored_lengths[ent_nx];
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && entry_count != $past(entry_count) |->
      out_valid && out_data[2] && entry_count == $past(entry_count) + CW'(1))
    else $error("entry count changed without a stored result");

  a_stored_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[2] |-> out_data[1:0] == STAT_ACCEPTED)
    else $error("stored flag on a rejected name");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pending_length <= LW'(NAME_LEN + 1))
    else $error("pending length past saturation");

endmodule
